@@ src/ktss_pkg.sv @@
// ----------------------------------------------------------------------------
// ktss_pkg: shared definitions for the key table sort and search block
// Field widths, stream widths, defaults, action codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ktss_pkg;

	localparam int unsigned DEPTH_DEFAULT    = 512;
	localparam int unsigned KEY_BITS_DEFAULT = 20;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned KEY_W    = 20;
	localparam int unsigned INDEX_W  = 9;
	localparam int unsigned COUNT_W  = 10;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 48;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD = 2'd0,
		ACT_SORT = 2'd1,
		ACT_FIND = 2'd2,
		ACT_READ = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FIND,
		ST_SORT_GET,
		ST_SORT_CMP,
		ST_SORT_WR,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ src/ktss_ram.sv @@
// ----------------------------------------------------------------------------
// ktss_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ktss_ram #(
	parameter int unsigned WIDTH = 20,
	parameter int unsigned DEPTH = 512,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ src/key_table_sort_and_search.sv @@
// ----------------------------------------------------------------------------
// key_table_sort_and_search: key table with exchange sort and linear search
// Stores up to DEPTH keys in a RAM; one shared compare unit walks the table
// under a small sequencer for load, sort, find and read actions.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals               Contents (low bit first)
// s_axis   in   tvalid tready tdata   action[2] key_in[20] index_in[9]
// m_axis   out  tvalid tready tdata   key_out[20] index_out[9] found
//                                     full_error count_out[10]
//
// Find walks the table one entry per cycle.
// Sort is paced by the single RAM read port feeding one compare unit.
// Reset empties the table at once; no clearing pass is needed.
// A new input is taken while the previous result still waits on m_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module key_table_sort_and_search #(
	parameter int unsigned DEPTH    = ktss_pkg::DEPTH_DEFAULT,
	parameter int unsigned KEY_BITS = ktss_pkg::KEY_BITS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// action[1:0], key_in[21:2], index_in[30:22], zero fill
	input  wire logic [ktss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// key_out[19:0], index_out[28:20], found[29], full_error[30],
	// count_out[40:31], zero fill
	output logic [ktss_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > ktss_pkg::INDEX_W) ? CW : ktss_pkg::INDEX_W;

	ktss_pkg::state_t  state_q, state_d;
	ktss_pkg::action_t action;

	logic [ktss_pkg::KEY_W-1:0]   key_in;
	logic [ktss_pkg::INDEX_W-1:0] index_in;
	logic [KEY_BITS-1:0]          key_ext;

	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       i_q, i_d;
	logic [CW-1:0]       j_q, j_d;
	logic [KEY_BITS-1:0] opnd_q, opnd_d;
	logic [CW:0]         j_nxt;
	logic [CW:0]         i_nxt;
	logic [CW:0]         i_two;
	logic                last_j;

	logic [ktss_pkg::KEY_W-1:0]   res_key_q, res_key_d;
	logic [ktss_pkg::INDEX_W-1:0] res_idx_q, res_idx_d;
	logic                         res_found_q, res_found_d;
	logic                         res_full_q, res_full_d;

	logic                              m_tvalid_q;
	logic [ktss_pkg::OUT_DATA_W-1:0]   m_tdata_q;
	logic                              out_load;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [AW-1:0]       ram_raddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [KEY_BITS-1:0] ram_rdata;
	logic                key_lt;
	logic                key_eq;

	assign action   = ktss_pkg::action_t'(s_axis_tdata[1:0]);
	assign key_in   = s_axis_tdata[21:2];
	assign index_in = s_axis_tdata[30:22];
	assign key_ext  = KEY_BITS'(key_in);

	assign key_lt = ram_rdata < opnd_q;
	assign key_eq = ram_rdata == opnd_q;

	assign j_nxt  = {1'b0, j_q} + (CW+1)'(1);
	assign i_nxt  = {1'b0, i_q} + (CW+1)'(1);
	assign i_two  = {1'b0, i_q} + (CW+1)'(2);
	assign last_j = j_nxt == {1'b0, count_q};

	assign s_axis_tready = state_q == ktss_pkg::ST_IDLE;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	ktss_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		i_d         = i_q;
		j_d         = j_q;
		opnd_d      = opnd_q;
		res_key_d   = res_key_q;
		res_idx_d   = res_idx_q;
		res_found_d = res_found_q;
		res_full_d  = res_full_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = opnd_q;
		ram_raddr   = '0;
		out_load    = 1'b0;
		unique case (state_q)
			ktss_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					res_key_d   = '0;
					res_idx_d   = '0;
					res_found_d = 1'b0;
					res_full_d  = 1'b0;
					state_d     = ktss_pkg::ST_DONE;
					unique case (action)
						ktss_pkg::ACT_LOAD: begin
							if (count_q < CW'(DEPTH)) begin
								ram_we    = 1'b1;
								ram_waddr = AW'(count_q);
								ram_wdata = key_ext;
								count_d   = count_q + CW'(1);
							end else begin
								res_full_d = 1'b1;
							end
						end
						ktss_pkg::ACT_SORT: begin
							if (count_q > CW'(1)) begin
								i_d     = '0;
								state_d = ktss_pkg::ST_SORT_GET;
							end
						end
						ktss_pkg::ACT_FIND: begin
							if (count_q != '0) begin
								opnd_d  = key_ext;
								j_d     = '0;
								state_d = ktss_pkg::ST_FIND;
							end
						end
						ktss_pkg::ACT_READ: begin
							if (CMPW'(index_in) < CMPW'(count_q)) begin
								ram_raddr = AW'(index_in);
								state_d   = ktss_pkg::ST_READ;
							end
						end
						default: begin
							state_d = ktss_pkg::ST_DONE;
						end
					endcase
				end
			end
			ktss_pkg::ST_READ: begin
				res_key_d   = ktss_pkg::KEY_W'(ram_rdata);
				res_found_d = 1'b1;
				state_d     = ktss_pkg::ST_DONE;
			end
			ktss_pkg::ST_FIND: begin
				if (key_eq) begin
					res_idx_d   = ktss_pkg::INDEX_W'(j_q);
					res_found_d = 1'b1;
					state_d     = ktss_pkg::ST_DONE;
				end else if (last_j) begin
					state_d = ktss_pkg::ST_DONE;
				end else begin
					j_d       = CW'(j_nxt);
					ram_raddr = AW'(j_nxt);
				end
			end
			ktss_pkg::ST_SORT_GET: begin
				opnd_d    = ram_rdata;
				j_d       = CW'(i_nxt);
				ram_raddr = AW'(i_nxt);
				state_d   = ktss_pkg::ST_SORT_CMP;
			end
			ktss_pkg::ST_SORT_CMP: begin
				if (key_lt) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(j_q);
					opnd_d    = ram_rdata;
				end
				if (last_j) begin
					state_d = ktss_pkg::ST_SORT_WR;
				end else begin
					j_d       = CW'(j_nxt);
					ram_raddr = AW'(j_nxt);
				end
			end
			ktss_pkg::ST_SORT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(i_q);
				if (i_two < {1'b0, count_q}) begin
					i_d       = CW'(i_nxt);
					ram_raddr = AW'(i_nxt);
					state_d   = ktss_pkg::ST_SORT_GET;
				end else begin
					state_d = ktss_pkg::ST_DONE;
				end
			end
			ktss_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ktss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ktss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ktss_pkg::ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q         <= i_d;
		j_q         <= j_d;
		opnd_q      <= opnd_d;
		res_key_q   <= res_key_d;
		res_idx_q   <= res_idx_d;
		res_found_q <= res_found_d;
		res_full_q  <= res_full_d;
		if (out_load) begin
			m_tdata_q <= {7'b0, ktss_pkg::COUNT_W'(count_q), res_full_q, res_found_q,
				res_idx_q, res_key_q};
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[30] |-> count_q == CW'(DEPTH))
		else $error("full flag reported while table not full");

	a_find_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ktss_pkg::ST_FIND |-> j_q < count_q)
		else $error("find walked past stored entries");

	a_sort_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ktss_pkg::ST_SORT_CMP |-> (i_q < j_q) && (j_q < count_q))
		else $error("sort indexes out of order or range");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && action == ktss_pkg::ACT_LOAD
		&& count_q < CW'(DEPTH) |=> count_q == $past(count_q) + CW'(1))
		else $error("load did not advance entry count");
`endif

endmodule

`default_nettype wire
